// ===== rtl/mecodo_pkg.sv =====
// ----------------------------------------------------------------------------
// mecodo_pkg
// Types, constants and tables shared by the mecanum odometry integrator.
// ----------------------------------------------------------------------------
package mecodo_pkg;

	localparam int WHEELS       = 4;
	localparam int CORDIC_STEPS = 16;
	localparam int VEL_N        = 3;
	localparam int ATAN_W       = 5;
	localparam int ITER_CW      = ATAN_W + 1;
	localparam int CFG_IDX_W    = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_DPC = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IWB = 8'd1;

	localparam logic [31:0] DPC_RESET  = 32'd658842;
	localparam logic [31:0] IWB_RESET  = 32'd1310720;
	localparam logic [31:0] HEAD_SCALE = 32'd683565276;
	localparam logic [31:0] INV_GAIN   = 32'd2608131496;
	localparam logic [31:0] US_PER_S   = 32'd1000000;
	localparam logic [31:0] RATE_LIM   = 32'd2148;

	typedef enum logic [3:0] {
		MUL_NONE, MUL_D0, MUL_D1, MUL_D2, MUL_D3, MUL_LIM, MUL_W,
		MUL_H0, MUL_H1, MUL_GX, MUL_GY, MUL_N0, MUL_N1, MUL_N2
	} mul_op_t;

	typedef enum logic [4:0] {
		ST_NONE, ST_S0, ST_S1, ST_S2, ST_S3, ST_LIM, ST_MIX, ST_DTH,
		ST_P1, ST_HEAD, ST_GX, ST_GY, ST_N0, ST_N1, ST_N2, ST_FOLD
	} st_op_t;

	typedef struct packed {
		logic              load;
		mul_op_t           mul_op;
		st_op_t            st_op;
		logic              div_start;
		logic              iter;
		logic [ATAN_W-1:0] iter_idx;
		logic              commit;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_sts_t;

	// arctangent of 2^-i in binary-angle units
	function automatic logic [31:0] atan_angle(logic [ATAN_W-1:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			5'd30: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/mecodo_ifs.sv =====
// ----------------------------------------------------------------------------
// mecodo_ifs
// Valid/ready channels of the odometry integrator: input, result, config.
// ----------------------------------------------------------------------------
interface mecodo_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] wheel1_count;
	logic signed [31:0] wheel2_count;
	logic signed [31:0] wheel3_count;
	logic signed [31:0] wheel4_count;
	logic        [23:0] period_us;
	modport source (output valid, wheel1_count, wheel2_count, wheel3_count,
		wheel4_count, period_us, input ready);
	modport sink (input valid, wheel1_count, wheel2_count, wheel3_count,
		wheel4_count, period_us, output ready);
endinterface

interface mecodo_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic        [31:0] heading_angle;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] yaw_rate;
	modport source (output valid, pos_x, pos_y, heading_angle, vel_x, vel_y,
		yaw_rate, input ready);
	modport sink (input valid, pos_x, pos_y, heading_angle, vel_x, vel_y,
		yaw_rate, output ready);
endinterface

interface mecodo_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mecodo_div.sv =====
// ----------------------------------------------------------------------------
// mecodo_div
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// ----------------------------------------------------------------------------
module mecodo_div
	import mecodo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [55:0] num,
	input  logic [23:0] den,
	output logic [31:0] quo,
	output logic        done
);

	localparam int DIV_BITS = 32;
	localparam int CNT_W    = $clog2(DIV_BITS + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [23:0]      rem_q;
	logic [31:0]      sh_q;
	logic [23:0]      den_q;
	logic [24:0]      trial;
	logic             qbit;

	assign trial = {rem_q, sh_q[31]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	// numerator high part is below the divisor, so the quotient fits 32 bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[55:32];
			sh_q  <= num[31:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? 24'(trial - {1'b0, den_q}) : trial[23:0];
			sh_q  <= {sh_q[30:0], qbit};
		end
	end

	assign quo  = sh_q;
	assign done = !busy_q;

endmodule

// ===== rtl/mecodo_ctrl.sv =====
// ----------------------------------------------------------------------------
// mecodo_ctrl
// Sequencer of the odometry integrator: multiply steps, rotation, commit.
// ----------------------------------------------------------------------------
module mecodo_ctrl
	import mecodo_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SEQ    = 4'b0010,
		S_ITER   = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	localparam logic [4:0] SEQ_LAST = 5'd17;

	state_t             state_q;
	logic [4:0]         step_q;
	logic [ITER_CW-1:0] it_q;
	logic               out_valid_q;
	logic               iter_on;
	logic               commit;
	mul_op_t            seq_mul;
	st_op_t             seq_st;

	assign iter_on = (state_q == S_ITER) && (it_q < ITER_CW'(CORDIC_STEPS));
	assign commit  = (state_q == S_COMMIT) && (!out_valid_q || out_ready);

	// product is registered, so each store of a product takes the previous step's multiply
	always_comb begin
		seq_mul = MUL_NONE;
		seq_st  = ST_NONE;
		unique case (step_q)
			5'd0:  begin seq_mul = MUL_D0;  end
			5'd1:  begin seq_mul = MUL_D1;  seq_st = ST_S0;   end
			5'd2:  begin seq_mul = MUL_D2;  seq_st = ST_S1;   end
			5'd3:  begin seq_mul = MUL_D3;  seq_st = ST_S2;   end
			5'd4:  begin seq_mul = MUL_LIM; seq_st = ST_S3;   end
			5'd5:  begin seq_st = ST_LIM;   end
			5'd6:  begin seq_st = ST_MIX;   end
			5'd7:  begin seq_mul = MUL_W;   end
			5'd8:  begin seq_st = ST_DTH;   end
			5'd9:  begin seq_mul = MUL_H0;  end
			5'd10: begin seq_mul = MUL_H1;  seq_st = ST_P1;   end
			5'd11: begin seq_mul = MUL_GX;  seq_st = ST_HEAD; end
			5'd12: begin seq_mul = MUL_GY;  seq_st = ST_GX;   end
			5'd13: begin seq_mul = MUL_N0;  seq_st = ST_GY;   end
			5'd14: begin seq_mul = MUL_N1;  seq_st = ST_N0;   end
			5'd15: begin seq_mul = MUL_N2;  seq_st = ST_N1;   end
			5'd16: begin seq_st = ST_N2;    end
			5'd17: begin seq_st = ST_FOLD;  end
			default: begin seq_mul = MUL_NONE; end
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.mul_op    = (state_q == S_SEQ) ? seq_mul : MUL_NONE;
		cmd.st_op     = (state_q == S_SEQ) ? seq_st : ST_NONE;
		cmd.div_start = (state_q == S_SEQ) && (step_q == SEQ_LAST);
		cmd.iter      = iter_on;
		cmd.iter_idx  = it_q[ATAN_W-1:0];
		cmd.commit    = commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (in_valid) state_q <= S_SEQ;
				end
				S_SEQ: begin
					step_q <= step_q + 1'b1;
					if (step_q == SEQ_LAST) begin
						it_q    <= '0;
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					if (iter_on) it_q <= it_q + 1'b1;
					else if (sts.div_done) state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/mecodo_dp.sv =====
// ----------------------------------------------------------------------------
// mecodo_dp
// Datapath: deltas, shared multiplier, heading, CORDIC, velocity dividers.
// ----------------------------------------------------------------------------
module mecodo_dp
	import mecodo_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic signed [31:0]   wheel1_count,
	input  logic signed [31:0]   wheel2_count,
	input  logic signed [31:0]   wheel3_count,
	input  logic signed [31:0]   wheel4_count,
	input  logic [23:0]          period_us,
	output logic signed [31:0]   pos_x,
	output logic signed [31:0]   pos_y,
	output logic [31:0]          heading_angle,
	output logic signed [31:0]   vel_x,
	output logic signed [31:0]   vel_y,
	output logic signed [31:0]   yaw_rate
);

	function automatic logic signed [31:0] sat32(logic signed [47:0] v);
		logic signed [31:0] r;
		if (!v[47] && (|v[46:31])) r = 32'sh7fffffff;
		else if (v[47] && !(&v[46:31])) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] rate_fix(logic neg, logic [32:0] val);
		logic [31:0] r;
		if (neg) r = (val > 33'h080000000) ? 32'h80000000 : 32'(33'd0 - val);
		else r = (val > 33'h07fffffff) ? 32'h7fffffff : val[31:0];
		return r;
	endfunction

	logic [31:0]        cnt_in [WHEELS];
	logic [31:0]        prev_q [WHEELS];
	logic signed [31:0] d_q    [WHEELS];
	logic signed [47:0] s_q    [WHEELS];
	logic [31:0]        pos_x_q, pos_y_q, head_q, dpc_q, iwb_q;
	logic [23:0]        per_q;
	logic [35:0]        lim_q;
	logic signed [47:0] dx_q, dy_q, dth_q;
	logic signed [31:0] w_q;
	logic [47:0]        p1_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic [55:0]        n_q    [VEL_N];
	logic signed [69:0] prod_q;

	logic signed [36:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [49:0] se     [WHEELS];
	logic signed [49:0] sum_x, sum_y, sum_w;
	logic [47:0]        acc48;
	logic [31:0]        hsum;
	logic signed [47:0] vsrc   [VEL_N];
	logic [47:0]        mag    [VEL_N];
	logic [VEL_N-1:0]   sat_v;
	logic [31:0]        quo    [VEL_N];
	logic [VEL_N-1:0]   lane_done;
	logic [31:0]        vel    [VEL_N];
	logic signed [35:0] sx, sy;
	logic [31:0]        new_px, new_py;

	assign cnt_in[0] = wheel1_count;
	assign cnt_in[1] = wheel2_count;
	assign cnt_in[2] = wheel3_count;
	assign cnt_in[3] = wheel4_count;

	assign vsrc[0] = dx_q;
	assign vsrc[1] = dy_q;
	assign vsrc[2] = dth_q;

	for (genvar k = 0; k < WHEELS; k++) begin : g_se
		assign se[k] = {{2{s_q[k][47]}}, s_q[k]};
	end

	assign sum_x = se[0] + se[1] + se[2] + se[3];
	assign sum_y = se[1] + se[2] - se[0] - se[3];
	assign sum_w = se[1] + se[3] - se[0] - se[2];

	// only bits 16..47 of the heading product are kept, so low 48 bits suffice
	assign acc48 = p1_q + {prod_q[23:0], 24'd0};
	assign hsum  = head_q + 32'h40000000;

	for (genvar k = 0; k < VEL_N; k++) begin : g_vel
		assign mag[k]   = vsrc[k][47] ? 48'(-vsrc[k]) : vsrc[k];
		assign sat_v[k] = (mag[k] >= {12'd0, lim_q});
		assign vel[k]   = (per_q == 24'd0) ? 32'd0 :
			rate_fix(vsrc[k][47], sat_v[k] ? 33'h100000000 : {1'b0, quo[k]});
		mecodo_div u_div (
			.clk   (clk),
			.arst_n(arst_n),
			.start (cmd.div_start),
			.num   (n_q[k]),
			.den   (per_q),
			.quo   (quo[k]),
			.done  (lane_done[k])
		);
	end

	assign sts.div_done = &lane_done;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			MUL_D0:  begin mul_a = 37'(d_q[0]); mul_b = {1'b0, dpc_q}; end
			MUL_D1:  begin mul_a = 37'(d_q[1]); mul_b = {1'b0, dpc_q}; end
			MUL_D2:  begin mul_a = 37'(d_q[2]); mul_b = {1'b0, dpc_q}; end
			MUL_D3:  begin mul_a = 37'(d_q[3]); mul_b = {1'b0, dpc_q}; end
			MUL_LIM: begin mul_a = {13'd0, per_q}; mul_b = {1'b0, RATE_LIM}; end
			MUL_W:   begin mul_a = 37'(w_q); mul_b = {1'b0, iwb_q}; end
			MUL_H0:  begin mul_a = {13'd0, dth_q[23:0]}; mul_b = {1'b0, HEAD_SCALE}; end
			MUL_H1:  begin mul_a = {13'd0, dth_q[47:24]}; mul_b = {1'b0, HEAD_SCALE}; end
			MUL_GX:  begin mul_a = 37'(sat32(dx_q)); mul_b = {1'b0, INV_GAIN}; end
			MUL_GY:  begin mul_a = 37'(sat32(dy_q)); mul_b = {1'b0, INV_GAIN}; end
			MUL_N0:  begin mul_a = {1'b0, mag[0][35:0]}; mul_b = {1'b0, US_PER_S}; end
			MUL_N1:  begin mul_a = {1'b0, mag[1][35:0]}; mul_b = {1'b0, US_PER_S}; end
			MUL_N2:  begin mul_a = {1'b0, mag[2][35:0]}; mul_b = {1'b0, US_PER_S}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign sx     = cx_q >>> cmd.iter_idx;
	assign sy     = cy_q >>> cmd.iter_idx;
	assign new_px = pos_x_q + cx_q[31:0];
	assign new_py = pos_y_q + cy_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WHEELS; k++) prev_q[k] <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q  <= '0;
			dpc_q   <= DPC_RESET;
			iwb_q   <= IWB_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DPC: dpc_q <= cfg_data;
					CFG_IWB: iwb_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				for (int k = 0; k < WHEELS; k++) prev_q[k] <= cnt_in[k];
			end
			if (cmd.st_op == ST_HEAD) head_q <= head_q + acc48[47:16];
			if (cmd.commit) begin
				pos_x_q <= new_px;
				pos_y_q <= new_py;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			for (int k = 0; k < WHEELS; k++) d_q[k] <= cnt_in[k] - prev_q[k];
			per_q <= period_us;
		end
		case (cmd.st_op)
			ST_S0:  s_q[0] <= prod_q[63:16];
			ST_S1:  s_q[1] <= prod_q[63:16];
			ST_S2:  s_q[2] <= prod_q[63:16];
			ST_S3:  s_q[3] <= prod_q[63:16];
			ST_LIM: lim_q  <= prod_q[35:0];
			ST_MIX: begin
				dx_q <= sum_x[49:2];
				dy_q <= sum_y[49:2];
				w_q  <= sat32(sum_w[49:2]);
			end
			ST_DTH: dth_q <= prod_q[63:16];
			ST_P1:  p1_q  <= prod_q[47:0];
			ST_GX:  cx_q  <= 36'($signed(prod_q[63:32]));
			ST_GY:  cy_q  <= 36'($signed(prod_q[63:32]));
			ST_N0:  n_q[0] <= prod_q[55:0];
			ST_N1:  n_q[1] <= prod_q[55:0];
			ST_N2:  n_q[2] <= prod_q[55:0];
			ST_FOLD: begin
				// heading outside the right half plane: turn by half a circle first
				if (hsum[31]) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
				end
				cz_q <= 34'(signed'({head_q[31] ^ hsum[31], head_q[30:0]}));
			end
			default: ;
		endcase
		if (cmd.iter) begin
			if (!cz_q[33]) begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				cz_q <= cz_q - $signed({2'b00, atan_angle(cmd.iter_idx)});
			end else begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				cz_q <= cz_q + $signed({2'b00, atan_angle(cmd.iter_idx)});
			end
		end
		if (cmd.commit) begin
			pos_x         <= new_px;
			pos_y         <= new_py;
			heading_angle <= head_q;
			vel_x         <= vel[0];
			vel_y         <= vel[1];
			yaw_rate      <= vel[2];
		end
	end

endmodule

// ===== rtl/mecanum_odometry_integrator.sv =====
// ----------------------------------------------------------------------------
// mecanum_odometry_integrator
// Mecanum wheel dead reckoning: position and body velocities in Q16.16, heading as a binary angle.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     word
//  in_ch    in   valid/ready   four wheel counts, period_us
//  out_ch   out  valid/ready   pos_x, pos_y, heading_angle, vel_x, vel_y, yaw_rate
//  cfg      in   valid/ready   index, data (ready always high)
//
// one word passes from accept to result through 18 sequence steps on the
// shared multiplier, then the 32-step velocity dividers, with the CORDIC
// iterations running alongside them
// a new word is taken once the previous result is in the output register
// reset clears counts, pose and heading and loads the register defaults
// a stalled output holds its word and delays only the commit of the next one
module mecanum_odometry_integrator
	import mecodo_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	mecodo_in_if.sink     in_ch,
	mecodo_out_if.source  out_ch,
	mecodo_cfg_if.sink    cfg
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	mecodo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mecodo_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.wheel1_count (in_ch.wheel1_count),
		.wheel2_count (in_ch.wheel2_count),
		.wheel3_count (in_ch.wheel3_count),
		.wheel4_count (in_ch.wheel4_count),
		.period_us    (in_ch.period_us),
		.pos_x        (out_ch.pos_x),
		.pos_y        (out_ch.pos_y),
		.heading_angle(out_ch.heading_angle),
		.vel_x        (out_ch.vel_x),
		.vel_y        (out_ch.vel_y),
		.yaw_rate     (out_ch.yaw_rate)
	);

endmodule

// ===== rtl/mecodo_chk.sv =====
// ----------------------------------------------------------------------------
// mecodo_chk
// Port-level checks of the odometry integrator, bound to the top level.
// ----------------------------------------------------------------------------
module mecodo_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pos_x,
	input logic [31:0] heading_angle
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x) && $stable(heading_angle))
		else $error("stalled result word changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work in flight");

endmodule

bind mecanum_odometry_integrator mecodo_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.pos_x        (out_ch.pos_x),
	.heading_angle(out_ch.heading_angle)
);
